// ===== rtl/scfa_pkg.sv =====
// Shared constants, types and codes for the size-class free-list allocator.
// No dependencies; the interfaces, class map and core import this package.
package scfa_pkg;

  localparam int NUM_CLASSES       = 13;
  localparam int ENTRIES_PER_CLASS = 16;
  localparam int MIN_CLASS_LOG2    = 16;

  localparam int SIZE_W    = 29;
  localparam int BADDR_W   = 32;
  localparam int CLASS_W   = 4;
  localparam int STATUS_W  = 3;
  localparam int LOG2_W    = 5;

  localparam int CLS_IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int FILL_W    = $clog2(ENTRIES_PER_CLASS + 1);
  localparam int STORE_DEPTH  = NUM_CLASSES * ENTRIES_PER_CLASS;
  localparam int STORE_ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(1) << 28;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_SERVED   = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FREED    = 3'd2,
    ST_FULL     = 3'd3,
    ST_SIZE_ERR = 3'd4
  } status_t;

  typedef struct packed {
    logic                err;
    logic [CLASS_W-1:0]  cls;
    logic [SIZE_W-1:0]   backing;
  } cls_info_t;

endpackage

// ===== rtl/scfa_if.sv =====
// Request and response channel interfaces (valid/ready) for the allocator.
// Depends on scfa_pkg for field widths.
interface scfa_req_if import scfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [SIZE_W-1:0]   request_size;
  logic [BADDR_W-1:0]  block_address;

  modport source (output valid, opcode, request_size, block_address, input ready);
  modport sink   (input valid, opcode, request_size, block_address, output ready);
endinterface

interface scfa_rsp_if import scfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BADDR_W-1:0]  granted_address;
  logic [CLASS_W-1:0]  size_class;
  logic [SIZE_W-1:0]   backing_bytes;

  modport source (output valid, status, granted_address, size_class, backing_bytes,
                  input ready);
  modport sink   (input valid, status, granted_address, size_class, backing_bytes,
                  output ready);
endinterface

// ===== rtl/scfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module scfa_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read enable
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/scfa_class_map.sv =====
// Maps a byte size to its size class, backing block size and error flag.
// Depends on scfa_pkg.
module scfa_class_map import scfa_pkg::*; (
  input  logic [SIZE_W-1:0] size,
  output cls_info_t         info
);

  // ceiling log2: bit length of (size-1), zero for sizes 0 and 1
  function automatic logic [LOG2_W-1:0] ceil_log2(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] m;
    logic [LOG2_W-1:0] lg;
    m  = v - SIZE_W'(1);
    lg = '0;
    if (v > SIZE_W'(1)) begin
      for (int i = 0; i < SIZE_W; i++) begin
        if (m[i]) lg = LOG2_W'(i + 1);
      end
    end
    return lg;
  endfunction

  logic [LOG2_W-1:0] lg_raw;
  logic [LOG2_W-1:0] lg;
  logic [LOG2_W-1:0] cls_full;
  logic              err;

  always_comb begin
    lg_raw   = ceil_log2(size);
    lg       = (lg_raw < LOG2_W'(MIN_CLASS_LOG2)) ? LOG2_W'(MIN_CLASS_LOG2) : lg_raw;
    cls_full = lg - LOG2_W'(MIN_CLASS_LOG2);
    err      = (size > SIZE_LIMIT) || (cls_full >= LOG2_W'(NUM_CLASSES));
    info.err = err;
    if (err) begin
      info.cls     = '0;
      info.backing = '0;
    end else begin
      info.cls     = CLASS_W'(cls_full);
      info.backing = SIZE_W'(1) << lg;
    end
  end

endmodule

// ===== rtl/size_class_free_list_allocator_core.sv =====
// Top level of the size-class free-list allocator: fill counts, address store,
// result stages. Depends on scfa_pkg, scfa_if, scfa_class_map and scfa_ram.
//
//   channel  port     direction  carries
//   request  in_req   sink       opcode, request_size, block_address
//   response out_rsp  source     status, granted_address, size_class, backing_bytes
//
// One request per cycle while the response is not stalled; each result passes
// through the address store read stage, then the output register.
// Fill counts update at the request transfer, so back-to-back requests to the
// same class see each other with no stall. Synchronous active-low reset clears
// the fill counts and valid flags; the address store needs no clearing. A stalled
// response holds, and one more request is taken into the read stage behind it.
module size_class_free_list_allocator_core import scfa_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  scfa_req_if.sink    in_req,
  scfa_rsp_if.source  out_rsp
);

  cls_info_t               info;
  logic [FILL_W-1:0]       fill_r [NUM_CLASSES];
  logic [CLS_IDX_W-1:0]    cls_idx;
  logic [FILL_W-1:0]       fill;
  logic                    accept;
  logic                    do_pop;
  logic                    do_push;
  status_t                 status;
  logic [STORE_ADDR_W-1:0] base;
  logic [STORE_ADDR_W-1:0] pop_addr;
  logic [STORE_ADDR_W-1:0] push_addr;
  logic [BADDR_W-1:0]      rd_data;

  logic                    s1_v_r;
  status_t                 s1_status_r;
  logic [CLASS_W-1:0]      s1_cls_r;
  logic [SIZE_W-1:0]       s1_backing_r;
  logic                    s1_move;

  logic                    out_v_r;
  status_t                 out_status_r;
  logic [BADDR_W-1:0]      out_addr_r;
  logic [CLASS_W-1:0]      out_cls_r;
  logic [SIZE_W-1:0]       out_backing_r;
  logic [BADDR_W-1:0]      out_addr_nxt;

  scfa_class_map u_class_map (
    .size (in_req.request_size),
    .info (info)
  );

  assign cls_idx = CLS_IDX_W'(info.cls);
  assign fill    = fill_r[cls_idx];
  assign s1_move = s1_v_r && (!out_v_r || out_rsp.ready);
  assign in_req.ready = !s1_v_r || s1_move;
  assign accept  = in_req.valid && in_req.ready;

  always_comb begin
    do_pop  = 1'b0;
    do_push = 1'b0;
    if (info.err) begin
      status = ST_SIZE_ERR;
    end else if (in_req.opcode == OP_ALLOC) begin
      if (fill == '0 || fill > FILL_W'(ENTRIES_PER_CLASS)) begin
        status = ST_EMPTY;
      end else begin
        status = ST_SERVED;
        do_pop = 1'b1;
      end
    end else begin
      if (fill >= FILL_W'(ENTRIES_PER_CLASS)) begin
        status = ST_FULL;
      end else begin
        status  = ST_FREED;
        do_push = 1'b1;
      end
    end
  end

  assign base      = STORE_ADDR_W'(cls_idx * ENTRIES_PER_CLASS);
  assign pop_addr  = base + STORE_ADDR_W'(fill - FILL_W'(1));
  assign push_addr = base + STORE_ADDR_W'(fill);

  scfa_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (BADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (accept && do_push),
    .waddr (push_addr),
    .wdata (in_req.block_address),
    .re    (accept && do_pop),
    .raddr (pop_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        fill_r[i] <= '0;
      end
    end else if (accept && do_pop) begin
      fill_r[cls_idx] <= fill - FILL_W'(1);
    end else if (accept && do_push) begin
      fill_r[cls_idx] <= fill + FILL_W'(1);
    end
  end

  // read stage: waits for the store's registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r  <= status;
      s1_cls_r     <= info.cls;
      s1_backing_r <= info.backing;
    end
  end

  assign out_addr_nxt = (s1_status_r == ST_SERVED) ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move) begin
      out_v_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_status_r  <= s1_status_r;
      out_addr_r    <= out_addr_nxt;
      out_cls_r     <= s1_cls_r;
      out_backing_r <= s1_backing_r;
    end
  end

  assign out_rsp.valid           = out_v_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.granted_address = out_addr_r;
  assign out_rsp.size_class      = out_cls_r;
  assign out_rsp.backing_bytes   = out_backing_r;

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    accept && do_pop |=> fill_r[$past(cls_idx)] == $past(fill) - FILL_W'(1))
    else $error("fill count not decremented after pop");

  a_push_increments: assert property (@(posedge clk) disable iff (!rst_n)
    accept && do_push |=> fill_r[$past(cls_idx)] == $past(fill) + FILL_W'(1))
    else $error("fill count not incremented after push");

  // read data only matters for a pop; other items may sit on a never-read store
  a_read_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_move |=> s1_v_r && $stable(s1_status_r) &&
      (s1_status_r != ST_SERVED || $stable(rd_data)))
    else $error("read stage lost its item while the output was stalled");

  a_served_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept && do_pop |-> fill != '0 && fill <= FILL_W'(ENTRIES_PER_CLASS))
    else $error("pop issued from an empty or overfull class");

endmodule
